// ----- hdl/fca_pkg.sv -----
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, codes and defaults of the cluster chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

    // default sizes and register reset
    localparam int DATA_BLOCKS_DEF = 2048;
    localparam int FILE_SLOTS_DEF  = 128;
    localparam int CFG_RESET       = 2048;

    // end of chain / empty marker
    localparam logic [15:0] EOC = 16'hFFFF;

    // operation codes
    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_SET_HEAD = 3'd1;
    localparam logic [2:0] OP_APPEND   = 3'd2;
    localparam logic [2:0] OP_FREE     = 3'd3;
    localparam logic [2:0] OP_LOCATE   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // input item
    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  file_slot;
        logic [10:0] block_number;
        logic [10:0] entry_index;
        logic [15:0] entry_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [15:0] block_index;
        logic [1:0]  status;
        logic [11:0] free_count;
    } t_out_item;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_RC_RD,
        S_RC_EV,
        S_IDLE,
        S_SC_RD,
        S_SC_EV,
        S_HD_RD,
        S_HD_EV,
        S_AP_RD,
        S_AP_EV,
        S_MK,
        S_PUT_RD,
        S_PUT_EV,
        S_FR_RD,
        S_FR_EV,
        S_LC_CHK,
        S_LC_EV,
        S_DONE
    } t_state;

endpackage

// ----- hdl/fca_ram.sv -----
// ----------------------------------------------------------------------------
// fca_ram
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fca_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fca_ctrl.sv -----
// ----------------------------------------------------------------------------
// fca_ctrl
// Sequencer that walks the table and the chains one memory read at a time.
// ----------------------------------------------------------------------------
module fca_ctrl
    import fca_pkg::*;
#(
    parameter int DATA_BLOCKS = DATA_BLOCKS_DEF,
    parameter int FILE_SLOTS  = FILE_SLOTS_DEF,
    parameter int AW          = $clog2(DATA_BLOCKS),
    parameter int HW          = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_valid,
    input  t_in_item      i_item,
    output logic          o_item_ready,
    input  logic          i_cfg_valid,
    input  logic [11:0]   i_cfg_data,
    output logic          o_cfg_ready,
    output logic          o_res_valid,
    output t_out_item     o_res,
    input  logic          i_res_taken,
    output logic          o_fat_we,
    output logic [AW-1:0] o_fat_waddr,
    output logic [15:0]   o_fat_wdata,
    output logic [AW-1:0] o_fat_raddr,
    input  logic [15:0]   i_fat_rdata,
    output logic          o_head_we,
    output logic [HW-1:0] o_head_waddr,
    output logic [15:0]   o_head_wdata,
    output logic [HW-1:0] o_head_raddr,
    input  logic [15:0]   i_head_rdata
);

    localparam int NW    = $clog2(DATA_BLOCKS + 1);
    localparam int MAXD  = (DATA_BLOCKS > FILE_SLOTS) ? DATA_BLOCKS : FILE_SLOTS;
    localparam int CW    = $clog2(MAXD + 1);
    localparam int RST_N = (CFG_RESET > DATA_BLOCKS) ? DATA_BLOCKS : CFG_RESET;

    t_state        r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [HW-1:0] r_slot, n_slot;
    logic [10:0]   r_pos, n_pos;
    logic [10:0]   r_j, n_j;
    logic [NW-1:0] r_idx, n_idx;
    logic [NW-1:0] r_steps, n_steps;
    logic [NW-1:0] r_n, n_n;
    logic [NW-1:0] r_used, n_used;
    logic [15:0]   r_cur, n_cur;
    logic [AW-1:0] r_fr, n_fr;
    logic [15:0]   r_blk, n_blk;
    logic [1:0]    r_status, n_status;
    logic [AW-1:0] r_put_addr, n_put_addr;
    logic [15:0]   r_put_val, n_put_val;
    t_state        r_put_ret, n_put_ret;
    logic [CW-1:0] r_clr, n_clr;

    logic [31:0]   w_cfg32, w_slot32, w_eidx32, w_free32;
    logic [NW-1:0] w_cfg_n, w_free;
    logic          w_slot_ok, w_cur_ok, w_rd_ok;

    // input decode and clamp of the block count
    assign w_cfg32   = 32'(i_cfg_data);
    assign w_slot32  = 32'(i_item.file_slot);
    assign w_eidx32  = 32'(i_item.entry_index);
    assign w_slot_ok = (w_slot32 < FILE_SLOTS);
    assign w_cfg_n   = (w_cfg32 == 32'd0) ? NW'(1) :
                       (w_cfg32 > DATA_BLOCKS) ? NW'(DATA_BLOCKS) : w_cfg32[NW-1:0];
    assign w_cur_ok  = (32'(r_cur) < DATA_BLOCKS);
    assign w_rd_ok   = (32'(i_fat_rdata) < DATA_BLOCKS);
    assign w_free    = r_n - r_used;
    assign w_free32  = 32'(w_free);

    // state and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_n     <= NW'(RST_N);
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_n     <= n_n;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_slot     <= n_slot;
        r_pos      <= n_pos;
        r_j        <= n_j;
        r_idx      <= n_idx;
        r_steps    <= n_steps;
        r_cur      <= n_cur;
        r_fr       <= n_fr;
        r_blk      <= n_blk;
        r_status   <= n_status;
        r_put_addr <= n_put_addr;
        r_put_val  <= n_put_val;
        r_put_ret  <= n_put_ret;
    end

    // next state and memory controls
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_slot       = r_slot;
        n_pos        = r_pos;
        n_j          = r_j;
        n_idx        = r_idx;
        n_steps      = r_steps;
        n_n          = r_n;
        n_used       = r_used;
        n_cur        = r_cur;
        n_fr         = r_fr;
        n_blk        = r_blk;
        n_status     = r_status;
        n_put_addr   = r_put_addr;
        n_put_val    = r_put_val;
        n_put_ret    = r_put_ret;
        n_clr        = r_clr;
        o_fat_we     = 1'b0;
        o_fat_waddr  = r_put_addr;
        o_fat_wdata  = r_put_val;
        o_fat_raddr  = r_cur[AW-1:0];
        o_head_we    = 1'b0;
        o_head_waddr = r_slot;
        o_head_wdata = EOC;
        o_head_raddr = r_slot;
        o_item_ready = 1'b0;
        o_cfg_ready  = 1'b0;
        o_res_valid  = 1'b0;

        case (r_state)
            // sweep both tables to their reset contents
            S_CLEAR: begin
                o_cfg_ready = 1'b1;
                if (32'(r_clr) < DATA_BLOCKS) begin
                    o_fat_we    = 1'b1;
                    o_fat_waddr = r_clr[AW-1:0];
                    o_fat_wdata = (r_clr == '0) ? EOC : 16'h0000;
                end
                if (32'(r_clr) < FILE_SLOTS) begin
                    o_head_we    = 1'b1;
                    o_head_waddr = r_clr[HW-1:0];
                    o_head_wdata = EOC;
                end
                if (r_clr == CW'(MAXD - 1)) begin
                    n_state = S_RC_RD;
                    n_idx   = '0;
                    n_used  = '0;
                end else begin
                    n_clr = r_clr + CW'(1);
                end
                if (i_cfg_valid) begin
                    n_n = w_cfg_n;
                end
            end

            // recount used entries below the block count
            S_RC_RD: begin
                o_cfg_ready = 1'b1;
                o_fat_raddr = r_idx[AW-1:0];
                if (r_idx >= r_n) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RC_EV;
                end
                if (i_cfg_valid) begin
                    n_n     = w_cfg_n;
                    n_idx   = '0;
                    n_used  = '0;
                    n_state = S_RC_RD;
                end
            end

            S_RC_EV: begin
                o_cfg_ready = 1'b1;
                if (i_fat_rdata != 16'h0000) begin
                    n_used = r_used + NW'(1);
                end
                n_idx   = r_idx + NW'(1);
                n_state = S_RC_RD;
                if (i_cfg_valid) begin
                    n_n    = w_cfg_n;
                    n_idx  = '0;
                    n_used = '0;
                end
            end

            // take an item and dispatch on its operation, a register write wins
            S_IDLE: begin
                o_item_ready = ~i_cfg_valid;
                o_cfg_ready  = 1'b1;
                if (i_item_valid && !i_cfg_valid) begin
                    n_op       = i_item.op;
                    n_slot     = w_slot32[HW-1:0];
                    n_pos      = i_item.block_number;
                    n_j        = '0;
                    n_blk      = EOC;
                    n_status   = ST_OK;
                    n_put_addr = w_eidx32[AW-1:0];
                    n_put_val  = i_item.entry_value;
                    n_put_ret  = S_DONE;
                    n_state    = S_DONE;
                    case (i_item.op)
                        OP_LOAD: begin
                            if (w_eidx32 < DATA_BLOCKS) begin
                                n_state = S_PUT_RD;
                            end
                        end
                        OP_SET_HEAD: begin
                            if (w_slot_ok) begin
                                o_head_we    = 1'b1;
                                o_head_waddr = w_slot32[HW-1:0];
                                o_head_wdata = i_item.entry_value;
                            end
                        end
                        OP_APPEND: begin
                            if (w_slot_ok) begin
                                n_idx   = '0;
                                n_state = S_SC_RD;
                            end
                        end
                        OP_FREE, OP_LOCATE: begin
                            if (w_slot_ok) begin
                                n_state = S_HD_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
                if (i_cfg_valid) begin
                    n_n     = w_cfg_n;
                    n_idx   = '0;
                    n_used  = '0;
                    n_state = S_RC_RD;
                end
            end

            // search for the lowest free block
            S_SC_RD: begin
                o_fat_raddr = r_idx[AW-1:0];
                if (r_idx >= r_n) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SC_EV;
                end
            end

            S_SC_EV: begin
                if (i_fat_rdata == 16'h0000) begin
                    n_fr    = r_idx[AW-1:0];
                    n_blk   = 16'(r_idx);
                    n_state = S_HD_RD;
                end else begin
                    n_idx   = r_idx + NW'(1);
                    n_state = S_SC_RD;
                end
            end

            // fetch the chain head
            S_HD_RD: begin
                n_state = S_HD_EV;
            end

            S_HD_EV: begin
                n_cur   = i_head_rdata;
                n_steps = '0;
                case (r_op)
                    OP_APPEND: begin
                        if (32'(i_head_rdata) < DATA_BLOCKS) begin
                            n_state = S_AP_RD;
                        end else begin
                            o_head_we    = 1'b1;
                            o_head_wdata = 16'(r_fr);
                            n_state      = S_MK;
                        end
                    end
                    OP_FREE: begin
                        n_state = S_FR_RD;
                    end
                    default: begin
                        n_state = S_LC_CHK;
                    end
                endcase
            end

            // walk to the tail of the chain
            S_AP_RD: begin
                if (32'(r_steps) < DATA_BLOCKS) begin
                    n_state = S_AP_EV;
                end else begin
                    n_put_addr = r_cur[AW-1:0];
                    n_put_val  = 16'(r_fr);
                    n_put_ret  = S_MK;
                    n_state    = S_PUT_RD;
                end
            end

            S_AP_EV: begin
                if (w_rd_ok) begin
                    n_cur   = i_fat_rdata;
                    n_steps = r_steps + NW'(1);
                    n_state = S_AP_RD;
                end else begin
                    n_put_addr = r_cur[AW-1:0];
                    n_put_val  = 16'(r_fr);
                    n_put_ret  = S_MK;
                    n_state    = S_PUT_RD;
                end
            end

            // mark the new block as chain end
            S_MK: begin
                n_put_addr = r_fr;
                n_put_val  = EOC;
                n_put_ret  = S_DONE;
                n_state    = S_PUT_RD;
            end

            // read-modify-write of one entry with used count upkeep
            S_PUT_RD: begin
                o_fat_raddr = r_put_addr;
                n_state     = S_PUT_EV;
            end

            S_PUT_EV: begin
                o_fat_we = 1'b1;
                if (32'(r_put_addr) < 32'(r_n)) begin
                    if (i_fat_rdata == 16'h0000 && r_put_val != 16'h0000) begin
                        n_used = r_used + NW'(1);
                    end else if (i_fat_rdata != 16'h0000 && r_put_val == 16'h0000 &&
                                 r_used != '0) begin
                        n_used = r_used - NW'(1);
                    end
                end
                n_state = r_put_ret;
            end

            // clear a chain link by link
            S_FR_RD: begin
                if (w_cur_ok && (32'(r_steps) < DATA_BLOCKS)) begin
                    n_state = S_FR_EV;
                end else begin
                    o_head_we = 1'b1;
                    n_state   = S_DONE;
                end
            end

            S_FR_EV: begin
                o_fat_we    = 1'b1;
                o_fat_waddr = r_cur[AW-1:0];
                o_fat_wdata = 16'h0000;
                if ((32'(r_cur) < 32'(r_n)) && i_fat_rdata != 16'h0000 && r_used != '0) begin
                    n_used = r_used - NW'(1);
                end
                n_cur   = i_fat_rdata;
                n_steps = r_steps + NW'(1);
                n_state = S_FR_RD;
            end

            // follow the chain to the requested position
            S_LC_CHK: begin
                if (!w_cur_ok) begin
                    n_status = ST_SHORT;
                    n_state  = S_DONE;
                end else if (r_j == r_pos) begin
                    n_blk   = r_cur;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LC_EV;
                end
            end

            S_LC_EV: begin
                n_cur   = i_fat_rdata;
                n_j     = r_j + 11'd1;
                n_state = S_LC_CHK;
            end

            // hand the result to the output register
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.block_index = r_blk;
    assign o_res.status      = r_status;
    assign o_res.free_count  = w_free32[11:0];

    // used count stays within the block count between items
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_used <= r_n))
        else $error("used count above block count");

    // freeing a link never raises the used count
    a_free_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FR_EV) |=> (r_used <= $past(r_used)))
        else $error("free step raised used count");

    // a failed append reports no block
    a_nospace_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_NO_SPACE) |-> (r_blk == EOC))
        else $error("no-space result carries a block");

    // table writes stay inside the table
    a_fat_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fat_we |-> (32'(o_fat_waddr) < DATA_BLOCKS))
        else $error("table write out of range");

endmodule

// ----- hdl/fat_chain_allocator.sv -----
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Cluster chain allocator over a block table and a chain head table.
// ----------------------------------------------------------------------------
// Usage: items enter on i_in_valid/i_in_item and are taken when o_in_stall
// is low; results leave on o_out_valid/o_out_item and are held while
// i_out_stall is high. The block count register is written on
// i_cfg_valid/o_cfg_ready/i_cfg_data while no item is in flight; each
// write starts a recount and holds off a waiting item.
// One item at a time; every table read is a read state then an
// evaluate state. Set head writes the head table directly, load is a
// read-modify-write, locate and free walk the chain, and append searches
// the lowest free block, links it at the tail and marks it as chain end.
// Each table has a single registered read port.
// After reset a clearing pass over max(DATA_BLOCKS, FILE_SLOTS) entries
// sets the tables, then a recount runs; items wait meanwhile,
// configuration writes are taken.
// A result waits in the output register while the next item is taken;
// the sequencer stalls in its final step only if that register is full.
// ----------------------------------------------------------------------------
module fat_chain_allocator
    import fca_pkg::*;
#(
    parameter int DATA_BLOCKS = DATA_BLOCKS_DEF,
    parameter int FILE_SLOTS  = FILE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    input  logic [11:0] i_cfg_data,
    output logic        o_cfg_ready
);

    localparam int AW = $clog2(DATA_BLOCKS);
    localparam int HW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;

    logic          w_item_ready, w_res_valid, w_take;
    t_out_item     w_res;
    logic          w_fat_we, w_head_we;
    logic [AW-1:0] w_fat_waddr, w_fat_raddr;
    logic [15:0]   w_fat_wdata, w_fat_rdata;
    logic [HW-1:0] w_head_waddr, w_head_raddr;
    logic [15:0]   w_head_wdata, w_head_rdata;
    logic          r_out_valid;
    t_out_item     r_out_item;

    fca_ctrl #(
        .DATA_BLOCKS (DATA_BLOCKS),
        .FILE_SLOTS  (FILE_SLOTS),
        .AW          (AW),
        .HW          (HW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in_valid),
        .i_item       (i_in_item),
        .o_item_ready (w_item_ready),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_taken  (w_take),
        .o_fat_we     (w_fat_we),
        .o_fat_waddr  (w_fat_waddr),
        .o_fat_wdata  (w_fat_wdata),
        .o_fat_raddr  (w_fat_raddr),
        .i_fat_rdata  (w_fat_rdata),
        .o_head_we    (w_head_we),
        .o_head_waddr (w_head_waddr),
        .o_head_wdata (w_head_wdata),
        .o_head_raddr (w_head_raddr),
        .i_head_rdata (w_head_rdata)
    );

    fca_ram #(
        .DEPTH (DATA_BLOCKS),
        .AW    (AW)
    ) u_fat_ram (
        .i_clk   (i_clk),
        .i_we    (w_fat_we),
        .i_waddr (w_fat_waddr),
        .i_wdata (w_fat_wdata),
        .i_raddr (w_fat_raddr),
        .o_rdata (w_fat_rdata)
    );

    fca_ram #(
        .DEPTH (FILE_SLOTS),
        .AW    (HW)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (w_head_waddr),
        .i_wdata (w_head_wdata),
        .i_raddr (w_head_raddr),
        .o_rdata (w_head_rdata)
    );

    assign o_in_stall = ~w_item_ready;

    // output register, loads when empty or draining
    assign w_take = w_res_valid & (~r_out_valid | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
